// File: rtl/core/tats_pkg.sv
// Shared types, codes and constants of the tick alarm table scheduler.
package tats_pkg;

  localparam int unsigned NUM_ENTRIES_DEF      = 16;
  localparam int unsigned TASK_ENTRIES_DEF     = 4;
  localparam int unsigned TICKS_PER_SECOND_DEF = 60;

  localparam int unsigned TIME_W   = 31;
  localparam int unsigned EXTRA_W  = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned SECS_W   = 32;
  localparam int unsigned QUANT_W  = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [TIME_W-1:0]  NO_ALARM      = 31'h7FFF_FFFF;
  localparam logic [TIME_W-1:0]  TIME_MAX      = 31'h7FFF_FFFE;
  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_QUANTUM = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_SECONDS  = 4'd1;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_ALARM = 2'd1,
    OP_GET_TIME  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_TICK_DONE = 2'd0,
    KIND_FIRED     = 2'd1,
    KIND_SET       = 2'd2,
    KIND_TIME      = 2'd3
  } kind_e;

  typedef struct packed {
    logic in_ready;
    logic exec;
    logic prime;
    logic scan_adv;
    logic div_step;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic       in_fire;
    logic [1:0] in_op;
    logic [1:0] op;
    logic       need_scan;
    logic       scan_fire;
    logic       scan_last;
    logic       slot_free;
  } sts_t;

endpackage

// File: rtl/core/tats_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface tats_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [tats_pkg::EXTRA_W-1:0] extra_ticks;
  logic [tats_pkg::IDX_W-1:0]  entry_index;
  logic [tats_pkg::TIME_W-1:0] alarm_delta;
  logic                        billed_is_previous;

  modport source (output valid, opcode, extra_ticks, entry_index, alarm_delta,
                  billed_is_previous, input ready);
  modport sink   (input valid, opcode, extra_ticks, entry_index, alarm_delta,
                  billed_is_previous, output ready);
endinterface

interface tats_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [tats_pkg::IDX_W-1:0]  fired_entry;
  logic [tats_pkg::SECS_W-1:0] seconds_now;
  logic                        schedule_request;
  logic                        last;

  modport source (output valid, kind, fired_entry, seconds_now, schedule_request,
                  last, input ready);
  modport sink   (input valid, kind, fired_entry, seconds_now, schedule_request,
                  last, output ready);
endinterface

interface tats_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tats_pkg::CFG_IDX_W-1:0] index;
  logic [tats_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/tats_datapath.sv
// Datapath: time, quantum, alarm table with valid bits, min scan, reciprocal divider, output register.
module tats_datapath #(
  parameter int unsigned NUM_ENTRIES      = tats_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned TASK_ENTRIES     = tats_pkg::TASK_ENTRIES_DEF,
  parameter int unsigned TICKS_PER_SECOND = tats_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tats_in_if.sink        in_i,
  tats_out_if.source     out_o,
  tats_cfg_if.sink       cfg_i,
  input  tats_pkg::cmd_t cmd_i,
  output tats_pkg::sts_t sts_o
);
  import tats_pkg::*;

  localparam int unsigned IW     = $clog2(NUM_ENTRIES);
  localparam int unsigned DIV_SH = TIME_W + $clog2(TICKS_PER_SECOND);
  localparam int unsigned PROD_W = TIME_W + 32;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << DIV_SH) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
  localparam logic [31:0] RECIP = RECIP_WIDE[31:0];

  logic [QUANT_W-1:0] sched_quantum_q;
  logic [SECS_W-1:0]  boot_seconds_q;

  logic [1:0]         op_q;
  logic [EXTRA_W-1:0] extra_q;
  logic [IDX_W-1:0]   idx_q;
  logic [TIME_W-1:0]  delta_q;
  logic               billed_q;

  logic [TIME_W-1:0]  current_time_q;
  logic [TIME_W-1:0]  nearest_q;
  logic [QUANT_W-1:0] quantum_count_q;
  logic               sched_q;

  logic [TIME_W-1:0]      mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_q;
  logic [TIME_W-1:0]      rdata_q;
  logic                   rvalid_q;
  logic [IW-1:0]          rd_addr;
  logic [IW-1:0]          scan_idx_q;
  logic [TIME_W-1:0]      min_q;

  logic [TIME_W-1:0]    quot_q;
  logic [PROD_W-1:0]    div_prod;

  logic               out_valid_q;
  logic [1:0]         out_kind_q;
  logic [IDX_W-1:0]   out_entry_q;
  logic [SECS_W-1:0]  out_secs_q;
  logic               out_sched_q;
  logic               out_last_q;

  logic [TIME_W:0]    tick_sum;
  logic [TIME_W-1:0]  tick_time;
  logic [TIME_W:0]    set_sum;
  logic [TIME_W-1:0]  set_deadline;
  logic               set_in_range;
  logic [IW-1:0]      set_addr;
  logic               mem_we;
  logic [QUANT_W-1:0] quant_dec;
  logic               is_tick;
  logic [TIME_W-1:0]  eff;
  logic               expired;
  logic [TIME_W-1:0]  min_new;
  logic               scan_last;
  logic               scan_fire;
  logic               slot_free;
  logic [SECS_W:0]    secs_sum;
  logic [SECS_W-1:0]  secs_sat;
  logic               fire_load;

  assign in_i.ready  = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;

  assign is_tick      = (op_q == OP_TICK);
  assign tick_sum     = {1'b0, current_time_q} + (TIME_W+1)'(extra_q) + 32'd1;
  assign tick_time    = (tick_sum > {1'b0, TIME_MAX}) ? TIME_MAX : tick_sum[TIME_W-1:0];
  assign set_sum      = {1'b0, current_time_q} + {1'b0, delta_q};
  assign set_deadline = (set_sum > {1'b0, NO_ALARM}) ? NO_ALARM : set_sum[TIME_W-1:0];
  assign set_in_range = (32'(idx_q) < NUM_ENTRIES);
  assign set_addr     = IW'(idx_q);
  assign mem_we       = cmd_i.exec && !is_tick && set_in_range;
  assign quant_dec    = quantum_count_q - 8'd1;

  assign eff       = rvalid_q ? rdata_q : NO_ALARM;
  assign expired   = is_tick && (eff <= current_time_q);
  assign min_new   = (!expired && (eff < min_q)) ? eff : min_q;
  assign scan_last = (scan_idx_q == IW'(NUM_ENTRIES - 1));
  assign scan_fire = expired && (32'(scan_idx_q) < TASK_ENTRIES);
  assign slot_free = !out_valid_q || out_o.ready;
  assign fire_load = cmd_i.scan_adv && scan_fire;

  always_comb begin
    if (cmd_i.prime) begin
      rd_addr = '0;
    end else if (cmd_i.scan_adv && !scan_last) begin
      rd_addr = scan_idx_q + 1'b1;
    end else begin
      rd_addr = scan_idx_q;
    end
  end

  // exact quotient for any time below 2**TIME_W
  assign div_prod = PROD_W'(current_time_q) * PROD_W'(RECIP);
  assign secs_sum = {1'b0, boot_seconds_q} + (SECS_W+1)'(quot_q);
  assign secs_sat = secs_sum[SECS_W] ? '1 : secs_sum[SECS_W-1:0];

  assign sts_o.in_fire   = in_i.valid && in_i.ready;
  assign sts_o.in_op     = in_i.opcode;
  assign sts_o.op        = op_q;
  assign sts_o.need_scan = (nearest_q <= tick_time);
  assign sts_o.scan_fire = scan_fire;
  assign sts_o.scan_last = scan_last;
  assign sts_o.slot_free = slot_free;

  assign out_o.valid            = out_valid_q;
  assign out_o.kind             = out_kind_q;
  assign out_o.fired_entry      = out_entry_q;
  assign out_o.seconds_now      = out_secs_q;
  assign out_o.schedule_request = out_sched_q;
  assign out_o.last             = out_last_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[set_addr] <= set_deadline;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sts_o.in_fire) begin
      op_q     <= in_i.opcode;
      extra_q  <= in_i.extra_ticks;
      idx_q    <= in_i.entry_index;
      delta_q  <= in_i.alarm_delta;
      billed_q <= in_i.billed_is_previous;
    end
    if (cmd_i.prime) begin
      min_q <= NO_ALARM;
    end else if (cmd_i.scan_adv) begin
      min_q <= min_new;
    end
    if (cmd_i.div_step) begin
      quot_q <= TIME_W'(div_prod >> DIV_SH);
    end
    if (fire_load) begin
      out_kind_q  <= KIND_FIRED;
      out_entry_q <= IDX_W'(scan_idx_q);
      out_secs_q  <= '0;
      out_sched_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (cmd_i.emit_final) begin
      out_entry_q <= '0;
      out_last_q  <= 1'b1;
      case (op_q)
        OP_TICK: begin
          out_kind_q  <= KIND_TICK_DONE;
          out_secs_q  <= '0;
          out_sched_q <= sched_q;
        end
        OP_SET_ALARM: begin
          out_kind_q  <= KIND_SET;
          out_secs_q  <= '0;
          out_sched_q <= 1'b0;
        end
        default: begin
          out_kind_q  <= KIND_TIME;
          out_secs_q  <= secs_sat;
          out_sched_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_quantum_q <= QUANTUM_RESET;
      boot_seconds_q  <= '0;
      current_time_q  <= '0;
      nearest_q       <= NO_ALARM;
      quantum_count_q <= QUANTUM_RESET;
      sched_q         <= 1'b0;
      valid_q         <= '0;
      rvalid_q        <= 1'b0;
      scan_idx_q      <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_SCHED_QUANTUM) begin
          sched_quantum_q <= cfg_i.data[QUANT_W-1:0];
        end else if (cfg_i.index == CFG_BOOT_SECONDS) begin
          boot_seconds_q <= cfg_i.data;
        end
      end
      if (cmd_i.exec && is_tick) begin
        current_time_q <= tick_time;
        if (quant_dec == '0) begin
          quantum_count_q <= sched_quantum_q;
          sched_q         <= billed_q;
        end else begin
          quantum_count_q <= quant_dec;
          sched_q         <= 1'b0;
        end
      end
      if (mem_we) begin
        valid_q[set_addr] <= 1'b1;
      end
      rvalid_q <= valid_q[rd_addr];
      if (cmd_i.prime) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_adv) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        if (expired) begin
          valid_q[scan_idx_q] <= 1'b0;
        end
        if (scan_last) begin
          nearest_q <= min_new;
        end
      end
      if (fire_load || cmd_i.emit_final) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/tats_ctrl.sv
// Controller: sequences accept, execute, table scan, division and final result.
module tats_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tats_pkg::sts_t sts_i,
  output tats_pkg::cmd_t cmd_o
);
  import tats_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PRIME,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   adv;

  assign adv = !sts_i.scan_fire || sts_i.slot_free;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_fire) begin
          case (sts_i.in_op)
            OP_TICK, OP_SET_ALARM: state_d = ST_EXEC;
            OP_GET_TIME:           state_d = ST_DIV;
            default:               state_d = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.op == OP_TICK && !sts_i.need_scan) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_adv = adv;
        if (adv && sts_i.scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.emit_final = sts_i.slot_free;
        if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/tick_alarm_table_scheduler.sv
// Top level: tick-driven alarm table scheduler, controller plus datapath.
// Tick without expiry runs execute then done; get time runs divide then done. Tick with expiry
// or set alarm runs execute, prime, scan and done, reading one table entry per cycle through the
// single read port; a full output stalls the scan. Done registers the result, then idle accepts.
// Get time divides by TICKS_PER_SECOND with one registered reciprocal multiply.
// Reset: time 0, no alarms (entry valid bits cleared at once), quantum count 10.
module tick_alarm_table_scheduler #(
  parameter int unsigned NUM_ENTRIES      = tats_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned TASK_ENTRIES     = tats_pkg::TASK_ENTRIES_DEF,
  parameter int unsigned TICKS_PER_SECOND = tats_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tats_in_if.sink    in_i,
  tats_out_if.source out_o,
  tats_cfg_if.sink   cfg_i
);
  import tats_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tats_datapath #(
    .NUM_ENTRIES      (NUM_ENTRIES),
    .TASK_ENTRIES     (TASK_ENTRIES),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  tats_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

endmodule

// File: verif/tick_alarm_table_scheduler_tb.sv
// Self-checking testbench of the tick alarm table scheduler: predicted results vs. DUT output.
`timescale 1ns / 1ps

module tick_alarm_table_scheduler_tb;
  import tats_pkg::*;

  localparam logic [1:0]           OP_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd15;
  localparam int                   DRAIN_CYCLES = 40;
  localparam int                   PHASE_ITEMS  = 30;
  localparam int                   MAX_PRINTS   = 50;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [EXTRA_W-1:0] extra_ticks;
    logic [IDX_W-1:0]   entry_index;
    logic [TIME_W-1:0]  alarm_delta;
    logic               billed_is_previous;
  } alarm_req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  fired_entry;
    logic [SECS_W-1:0] seconds_now;
    logic              schedule_request;
    logic              last;
  } alarm_rsp_t;

  class alarm_scoreboard;
    logic [QUANT_W-1:0] quantum_reload;
    logic [SECS_W-1:0]  boot_secs;
    logic [TIME_W-1:0]  uptime;
    logic [TIME_W-1:0]  soonest;
    logic [TIME_W-1:0]  alarm_at [NUM_ENTRIES_DEF];
    logic [QUANT_W-1:0] quantum_left;
    alarm_rsp_t         expected_results [$];
    int                 errors;

    function new();
      quantum_reload = QUANTUM_RESET;
      boot_secs      = '0;
      uptime         = '0;
      soonest        = NO_ALARM;
      quantum_left   = QUANTUM_RESET;
      errors         = 0;
      foreach (alarm_at[i]) alarm_at[i] = NO_ALARM;
    endfunction

    function void apply_register_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == CFG_SCHED_QUANTUM) begin
        quantum_reload = data[QUANT_W-1:0];
      end else if (idx == CFG_BOOT_SECONDS) begin
        boot_secs = data;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void add_expected(logic [1:0] kind, logic [IDX_W-1:0] entry,
                               logic [SECS_W-1:0] secs, logic sched, logic last);
      alarm_rsp_t r;
      r.kind             = kind;
      r.fired_entry      = entry;
      r.seconds_now      = secs;
      r.schedule_request = sched;
      r.last             = last;
      expected_results.push_back(r);
    endfunction

    function void note_item(alarm_req_t req);
      logic [31:0]       t;
      logic [31:0]       whole_secs;
      logic [32:0]       secs;
      logic [TIME_W-1:0] m;
      logic              sched;
      int                i;
      case (req.opcode)
        OP_TICK: begin
          t = {1'b0, uptime} + 32'd1 + 32'(req.extra_ticks);
          if (t > {1'b0, TIME_MAX}) t = {1'b0, TIME_MAX};
          uptime = t[TIME_W-1:0];
          if (soonest <= uptime) begin
            m = NO_ALARM;
            for (i = 0; i < NUM_ENTRIES_DEF; i++) begin
              if (alarm_at[i] <= uptime) begin
                if (i < TASK_ENTRIES_DEF) add_expected(KIND_FIRED, 4'(i), '0, 1'b0, 1'b0);
                alarm_at[i] = NO_ALARM;
              end else if (alarm_at[i] < m) begin
                m = alarm_at[i];
              end
            end
            soonest = m;
          end
          quantum_left = quantum_left - 8'd1;
          sched = 1'b0;
          if (quantum_left == '0) begin
            quantum_left = quantum_reload;
            sched = req.billed_is_previous;
          end
          add_expected(KIND_TICK_DONE, '0, '0, sched, 1'b1);
        end
        OP_SET_ALARM: begin
          t = {1'b0, uptime} + {1'b0, req.alarm_delta};
          if (t > {1'b0, NO_ALARM}) t = {1'b0, NO_ALARM};
          if (req.entry_index < NUM_ENTRIES_DEF) alarm_at[req.entry_index] = t[TIME_W-1:0];
          m = NO_ALARM;
          for (i = 0; i < NUM_ENTRIES_DEF; i++) begin
            if (alarm_at[i] < m) m = alarm_at[i];
          end
          soonest = m;
          add_expected(KIND_SET, '0, '0, 1'b0, 1'b1);
        end
        OP_GET_TIME: begin
          whole_secs = 32'(uptime) / TICKS_PER_SECOND_DEF;
          secs = {1'b0, boot_secs} + {1'b0, whole_secs};
          if (secs > 33'h0_FFFF_FFFF) secs = 33'h0_FFFF_FFFF;
          add_expected(KIND_TIME, '0, secs[31:0], 1'b0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch: %s", msg);
    endtask

    task check_item(alarm_rsp_t got);
      alarm_rsp_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", got.kind));
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.fired_entry !== want.fired_entry)
        report_mismatch($sformatf("fired_entry %0d, want %0d", got.fired_entry,
                                  want.fired_entry));
      if (got.seconds_now !== want.seconds_now)
        report_mismatch($sformatf("seconds_now %0d, want %0d", got.seconds_now,
                                  want.seconds_now));
      if (got.schedule_request !== want.schedule_request)
        report_mismatch($sformatf("schedule_request %0b, want %0b", got.schedule_request,
                                  want.schedule_request));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;

  alarm_scoreboard sb;

  tats_in_if  in_if ();
  tats_out_if out_if ();
  tats_cfg_if cfg_if ();

  tick_alarm_table_scheduler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(64'd20_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_item({out_if.kind, out_if.fired_entry, out_if.seconds_now,
                     out_if.schedule_request, out_if.last});
  end

  function automatic alarm_req_t mk_req(logic [1:0] op, logic [EXTRA_W-1:0] extra,
                                        logic [IDX_W-1:0] idx, logic [TIME_W-1:0] delta,
                                        logic billed);
    alarm_req_t r;
    r.opcode             = op;
    r.extra_ticks        = extra;
    r.entry_index        = idx;
    r.alarm_delta        = delta;
    r.billed_is_previous = billed;
    return r;
  endfunction

  // mostly short deltas and small tick steps so that alarms actually expire
  function automatic alarm_req_t rand_req();
    alarm_req_t  r;
    int unsigned sel;
    r = mk_req(OP_TICK, EXTRA_W'($urandom), IDX_W'($urandom), TIME_W'($urandom),
               1'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 50) r.opcode = OP_TICK;
    else if (sel < 80) r.opcode = OP_SET_ALARM;
    else if (sel < 95) r.opcode = OP_GET_TIME;
    else r.opcode = OP_UNUSED;
    case ($urandom_range(0, 9))
      7: r.extra_ticks = '1;
      8: r.extra_ticks = '0;
      9: ;
      default: r.extra_ticks = EXTRA_W'($urandom_range(0, 15));
    endcase
    case ($urandom_range(0, 9))
      7: r.alarm_delta = '1;
      8: r.alarm_delta = '0;
      9: ;
      default: r.alarm_delta = TIME_W'($urandom_range(0, 300));
    endcase
    if ($urandom_range(0, 1))
      r.entry_index = IDX_W'($urandom_range(0, TASK_ENTRIES_DEF - 1));
    return r;
  endfunction

  task automatic send_item(input alarm_req_t req);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid              <= 1'b1;
    in_if.opcode             <= req.opcode;
    in_if.extra_ticks        <= req.extra_ticks;
    in_if.entry_index        <= req.entry_index;
    in_if.alarm_delta        <= req.alarm_delta;
    in_if.billed_is_previous <= req.billed_is_previous;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(req);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.apply_register_write(idx, data);
    @(posedge clk_i);
  endtask

  // unused opcode gives no result, so allow the longest operation to finish
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    alarm_req_t req;
    int         ph;
    int         n;
    sb = new();
    rst_ni                   <= 1'b0;
    in_if.valid              <= 1'b0;
    in_if.opcode             <= OP_TICK;
    in_if.extra_ticks        <= '0;
    in_if.entry_index        <= '0;
    in_if.alarm_delta        <= '0;
    in_if.billed_is_previous <= 1'b0;
    cfg_if.valid             <= 1'b0;
    cfg_if.index             <= CFG_SCHED_QUANTUM;
    cfg_if.data              <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(mk_req(OP_GET_TIME, '0, '0, '0, 1'b0));
    send_item(mk_req(OP_TICK, '0, '0, '0, 1'b1));
    send_item(mk_req(OP_SET_ALARM, '0, 4'd0, '0, 1'b0));
    send_item(mk_req(OP_SET_ALARM, '0, 4'd3, 31'd5, 1'b0));
    send_item(mk_req(OP_SET_ALARM, '0, 4'd4, 31'd1, 1'b0));
    send_item(mk_req(OP_SET_ALARM, '0, 4'd15, 31'd2, 1'b0));
    send_item(mk_req(OP_SET_ALARM, '0, 4'd1, '1, 1'b0));
    send_item(mk_req(OP_UNUSED, EXTRA_W'($urandom), IDX_W'($urandom), TIME_W'($urandom),
                     1'($urandom)));
    send_item(mk_req(OP_TICK, '1, '0, '0, 1'b1));
    send_item(mk_req(OP_SET_ALARM, '0, 4'd2, 31'd10, 1'b0));
    send_item(mk_req(OP_TICK, 16'd8, '0, '0, 1'b0));
    send_item(mk_req(OP_TICK, '0, '0, '0, 1'b0));
    send_item(mk_req(OP_SET_ALARM, '0, 4'd5, 31'd3, 1'b0));
    send_item(mk_req(OP_SET_ALARM, '0, 4'd0, 31'd3, 1'b0));
    send_item(mk_req(OP_TICK, 16'd2, '0, '0, 1'b0));
    repeat (5) send_item(mk_req(OP_TICK, '0, '0, '0, 1'b1));
    send_item(mk_req(OP_GET_TIME, '0, '0, '0, 1'b0));
    send_item(mk_req(OP_TICK, '1, '0, '0, 1'b0));
    send_item(mk_req(OP_GET_TIME, '0, '0, '0, 1'b0));

    for (ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
          write_reg(CFG_SCHED_QUANTUM, 32'd1);
          write_reg(CFG_BOOT_SECONDS, 32'hFFFF_FFFF);
          write_reg(CFG_UNMAPPED, $urandom);
        end
        1: begin
          src_idle_pct  = 73;
          snk_stall_pct = 0;
          write_reg(CFG_SCHED_QUANTUM, 32'd255);
          write_reg(CFG_BOOT_SECONDS, 32'd0);
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 73;
          write_reg(CFG_SCHED_QUANTUM, 32'd0);
          write_reg(CFG_BOOT_SECONDS, $urandom);
        end
        default: begin
          src_idle_pct  = 34;
          snk_stall_pct = 34;
          write_reg(CFG_SCHED_QUANTUM, $urandom_range(1, 255));
          write_reg(CFG_BOOT_SECONDS, $urandom);
        end
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        req = rand_req();
        send_item(req);
        if (req.opcode != OP_UNUSED) n++;
      end
    end

    settle();
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/tats_pkg.sv
rtl/core/tats_if.sv
rtl/core/tats_datapath.sv
rtl/core/tats_ctrl.sv
rtl/core/tick_alarm_table_scheduler.sv
verif/tick_alarm_table_scheduler_tb.sv
